[src/oli_pkg.sv]
// Package for the ordered list block: sizes, operation and status codes,
// and the per-cell control struct. No dependencies.
package oli_pkg;

  localparam int CAPACITY = 16;
  localparam int ELEM_W   = 32;
  localparam int POS_W    = 5;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  // Width wide enough to compare a position against length + 1 without wrap.
  localparam int CMP_W    = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;
  localparam int STAT_W   = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic load;        // take the inserted value
    logic shift_up;    // take the left neighbour's entry
    logic shift_down;  // take the right neighbour's entry
  } cell_ctrl_t;

endpackage

[src/oli_cell.sv]
// One storage cell of the ordered list chain: holds one entry and takes
// the new value or a neighbour's entry. Depends on oli_pkg.
module oli_cell (
  input  logic                      clk,
  input  oli_pkg::cell_ctrl_t       ctrl,
  input  logic [oli_pkg::ELEM_W-1:0] ins_value,
  input  logic [oli_pkg::ELEM_W-1:0] left_data,
  input  logic [oli_pkg::ELEM_W-1:0] right_data,
  output logic [oli_pkg::ELEM_W-1:0] data
);
  import oli_pkg::*;

  // Entry storage has no reset: it is read only after being written.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= ins_value;
    end else if (ctrl.shift_up) begin
      data <= left_data;
    end else if (ctrl.shift_down) begin
      data <= right_data;
    end
  end

endmodule

[src/ordered_list_insert_delete_top.sv]
// Ordered list, insert and delete at a 1-based position: one beat in, one beat out.
// The result beat is registered; throughput 1 beat per cycle while the output is not
// stalled, set by the parallel shift of the cell chain and the output register.
// Reset (rst, synchronous, active high) empties the list and drops any pending result;
// entry contents are not cleared and are never read before being written.
// Depends on oli_pkg and oli_cell.
module ordered_list_insert_delete_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              opcode,
  input  logic [oli_pkg::POS_W-1:0]         position,
  input  logic signed [oli_pkg::ELEM_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [oli_pkg::STAT_W-1:0]        status,
  output logic signed [oli_pkg::ELEM_W-1:0] removed_value,
  output logic [oli_pkg::LEN_W-1:0]         list_length
);
  import oli_pkg::*;

  logic [LEN_W-1:0]  length;
  logic [LEN_W-1:0]  length_next;
  logic              accept;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  len_ext;
  logic [CMP_W-1:0]  slot;
  logic              ins_range_err;
  logic              del_range_err;
  logic              full;
  logic              do_insert;
  logic              do_delete;
  logic [STAT_W-1:0] status_next;
  logic [ELEM_W-1:0] removed_next;

  logic [ELEM_W-1:0] cell_data [CAPACITY];
  cell_ctrl_t        cell_ctrl [CAPACITY];

  // A new beat may enter whenever the output register is empty or being drained.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Range and capacity checks. The range test takes precedence over the full test.
  assign pos_ext       = CMP_W'(position);
  assign len_ext       = CMP_W'(length);
  assign slot          = pos_ext - CMP_W'(1);
  assign ins_range_err = (position == '0) || (pos_ext > len_ext + CMP_W'(1));
  assign del_range_err = (position == '0) || (pos_ext > len_ext);
  assign full          = (len_ext == CMP_W'(CAPACITY));
  assign do_insert     = accept && (opcode == OP_INSERT) && !ins_range_err && !full;
  assign do_delete     = accept && (opcode == OP_DELETE) && !del_range_err;

  always_comb begin
    status_next = ST_DONE;
    if (opcode == OP_INSERT) begin
      if (ins_range_err) begin
        status_next = ST_RANGE;
      end else if (full) begin
        status_next = ST_FULL;
      end
    end else if (del_range_err) begin
      status_next = ST_RANGE;
    end
  end

  always_comb begin
    length_next = length;
    if (do_insert) begin
      length_next = length + LEN_W'(1);
    end else if (do_delete) begin
      length_next = length - LEN_W'(1);
    end
  end

  // Pick out the entry at the delete slot: and-or over the cells, one term per cell; zero unless a valid delete.
  always_comb begin
    removed_next = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot == CMP_W'(i)) begin
        removed_next = removed_next | cell_data[i];
      end
    end
    if (opcode != OP_DELETE || del_range_err) begin
      removed_next = '0;
    end
  end

  // Cell chain. On insert, the slot cell loads the value and every cell above it
  // takes its left neighbour; on delete, the slot cell and every cell above it take
  // their right neighbour. Cells below the slot hold.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ELEM_W-1:0] left_d;
    logic [ELEM_W-1:0] right_d;

    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end

    assign cell_ctrl[g].load       = do_insert && (slot == CMP_W'(g));
    assign cell_ctrl[g].shift_up   = do_insert && (slot <  CMP_W'(g));
    assign cell_ctrl[g].shift_down = do_delete && (slot <= CMP_W'(g));

    oli_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[g]),
      .ins_value  (value),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[g])
    );
  end

  // Length register and output handshake state.
  always_ff @(posedge clk) begin
    if (rst) begin
      length    <= '0;
      out_valid <= 1'b0;
    end else begin
      length <= length_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: load on every accepted beat, hold while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= status_next;
      removed_value <= removed_next;
      list_length   <= length_next;
    end
  end

endmodule

[src/oli_checker.sv]
// Port-level checker for the ordered list block, bound to the top level.
// Depends on oli_pkg and ordered_list_insert_delete_top.
module oli_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              opcode,
  input logic [oli_pkg::POS_W-1:0]         position,
  input logic signed [oli_pkg::ELEM_W-1:0] value,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [oli_pkg::STAT_W-1:0]        status,
  input logic signed [oli_pkg::ELEM_W-1:0] removed_value,
  input logic [oli_pkg::LEN_W-1:0]         list_length
);
  import oli_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat shown straight after reset");

  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (list_length <= LEN_W'(CAPACITY)))
    else $error("list length beyond capacity");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (list_length == LEN_W'(CAPACITY)))
    else $error("full status on a list that is not full");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_DONE) |-> (removed_value == '0))
    else $error("rejected beat carries a removed value");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(status) && $stable(removed_value) && $stable(list_length)))
    else $error("stalled result beat changed");

endmodule

bind ordered_list_insert_delete_top oli_checker u_oli_checker (.*);

[tb/sv/ordered_list_checker.sv]
// Checker for the ordered list block: watches both channels, keeps its own copy of
// the list and compares every result beat with the oldest predicted outcome.
// Depends on oli_pkg.
module ordered_list_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       opcode,
  input  logic [oli_pkg::POS_W-1:0]  position,
  input  logic [oli_pkg::ELEM_W-1:0] value,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [oli_pkg::STAT_W-1:0] status,
  input  logic [oli_pkg::ELEM_W-1:0] removed_value,
  input  logic [oli_pkg::LEN_W-1:0]  list_length,
  output int                         mismatch_count,
  output int                         outstanding
);
  import oli_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ELEM_W-1:0] removed;
    logic [LEN_W-1:0]  len;
  } list_result_t;

  logic [ELEM_W-1:0] shadow_cells [CAPACITY];
  int                shadow_len;
  list_result_t      pending_outcomes [$];
  list_result_t      oldest;
  int                result_beats;

  // Apply one operation to the shadow list and return the outcome it should give.
  function automatic list_result_t apply_list_op(input logic op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [ELEM_W-1:0] val);
    list_result_t res;
    int           p;
    p           = int'(pos);
    res.status  = ST_DONE;
    res.removed = '0;
    if (op == OP_INSERT) begin
      if (p < 1 || p > shadow_len + 1) begin
        res.status = ST_RANGE;
      end else if (shadow_len >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        for (int i = shadow_len; i > p - 1; i--) shadow_cells[i] = shadow_cells[i-1];
        shadow_cells[p-1] = val;
        shadow_len++;
      end
    end else begin
      if (p < 1 || p > shadow_len) begin
        res.status = ST_RANGE;
      end else begin
        res.removed = shadow_cells[p-1];
        for (int i = p - 1; i + 1 < shadow_len; i++) shadow_cells[i] = shadow_cells[i+1];
        shadow_len--;
      end
    end
    res.len = shadow_len[LEN_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [ELEM_W-1:0] got,
                                 input logic [ELEM_W-1:0] want);
    $display("ordered_list_checker: result beat %0d, %s: got 0x%0h, expected 0x%0h",
             result_beats, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      shadow_len     = 0;
      result_beats   = 0;
      mismatch_count = 0;
      pending_outcomes.delete();
    end else begin
      // Check the result beat first, then queue the prediction for a new input beat.
      if (out_valid && out_ready) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result with nothing expected", ELEM_W'(list_length), '0);
        end else begin
          oldest = pending_outcomes.pop_front();
          if (status !== oldest.status)
            report_mismatch("status", ELEM_W'(status), ELEM_W'(oldest.status));
          if (removed_value !== oldest.removed)
            report_mismatch("removed_value", removed_value, oldest.removed);
          if (list_length !== oldest.len)
            report_mismatch("list_length", ELEM_W'(list_length), ELEM_W'(oldest.len));
        end
        result_beats++;
      end
      if (in_valid && in_ready)
        pending_outcomes.push_back(apply_list_op(opcode, position, value));
    end
    outstanding = pending_outcomes.size();
  end

endmodule

[tb/sv/ordered_list_insert_delete_top_tb.sv]
// Testbench top for the ordered list block: clock, reset, stimulus and verdict.
// Prediction and comparison sit in ordered_list_checker; depends on oli_pkg.
module ordered_list_insert_delete_top_tb;
  import oli_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  // The limit leaves a wide margin over the slowest correct run.
  localparam int CYCLE_LIMIT  = 200000;

  // Direction of the random traffic within one stretch of items.
  typedef enum logic [1:0] {TREND_GROW, TREND_SHRINK, TREND_CHURN} trend_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic                     opcode;
  logic [POS_W-1:0]         position;
  logic signed [ELEM_W-1:0] value;
  logic                     out_valid;
  logic                     out_ready;
  logic [STAT_W-1:0]        status;
  logic signed [ELEM_W-1:0] removed_value;
  logic [LEN_W-1:0]         list_length;

  int mismatch_count;
  int outstanding;
  int cycle_count = 0;
  // Length the list should reach once every beat sent so far has been applied;
  // used only to steer positions into the valid range.
  int fill_level  = 0;

  ordered_list_insert_delete_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .position      (position),
    .value         (value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .removed_value (removed_value),
    .list_length   (list_length)
  );

  ordered_list_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .position       (position),
    .value          (value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .removed_value  (removed_value),
    .list_length    (list_length),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** ordered_list_insert_delete_top: FAILED **");
      $finish;
    end
  end

  // Percentage of steps that carry an idle gap: none, light or heavy.
  function automatic int pick_busy();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 25;
      default: return 60;
    endcase
  endfunction

  // Idle length: none unless the busy-percentage draw hits, mostly short when present, now and then long.
  function automatic int idle_len(input int busy);
    if ($urandom_range(0, 99) >= busy) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Mix plain random values with the signed extremes and small numbers.
  function automatic logic [ELEM_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      4, 5:    return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // Offer one beat (entered at a falling edge), hold it until accepted, and
  // return at the next falling edge with valid still high.
  task automatic send_beat(input logic op, input logic [POS_W-1:0] pos,
                           input logic [ELEM_W-1:0] val);
    in_valid = 1'b1;
    opcode   = op;
    position = pos;
    value    = val;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (op == OP_INSERT) begin
      if (pos >= 1 && pos <= fill_level + 1 && fill_level < CAPACITY) fill_level++;
    end else if (pos >= 1 && pos <= fill_level) begin
      fill_level--;
    end
  endtask

  // Receiver: stretches of random back-pressure, with a long hold-off every
  // sixth stretch so that the block fills up and stalls its input.
  initial begin
    int stretch;
    int rx_busy;
    int stall;
    stretch   = 0;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (stretch % 6 == 5) begin
        out_ready = 1'b0;
        repeat (80) @(negedge clk);
      end else begin
        rx_busy = pick_busy();
        repeat (40) begin
          stall = idle_len(rx_busy);
          if (stall > 0) begin
            out_ready = 1'b0;
            repeat (stall) @(negedge clk);
          end
          out_ready = 1'b1;
          @(negedge clk);
        end
      end
      stretch++;
    end
  end

  // Sender: reset, directed beats, random beats, then drain and give the verdict.
  initial begin
    int               gap;
    int               tx_busy;
    int               top_pos;
    trend_t           trend;
    logic             op;
    logic [POS_W-1:0] pos;
    rst      = 1'b1;
    in_valid = 1'b0;
    opcode   = OP_INSERT;
    position = '0;
    value    = '0;
    tx_busy  = 0;
    trend    = TREND_CHURN;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: rejections on an empty list first.
    send_beat(OP_DELETE, 5'd1, 32'h1234_5678);   // delete from empty list
    send_beat(OP_INSERT, 5'd0, 32'h0000_0001);   // position zero
    send_beat(OP_INSERT, 5'd2, 32'h0000_0002);   // beyond length + 1
    // Insert at front, back and middle with the signed extremes.
    send_beat(OP_INSERT, 5'd1, 32'h7fff_ffff);
    send_beat(OP_INSERT, 5'd1, 32'h8000_0000);
    send_beat(OP_INSERT, 5'd3, 32'hffff_ffff);
    send_beat(OP_INSERT, 5'd2, 32'h0000_0000);
    // Delete rejections, then middle and last entry.
    send_beat(OP_DELETE, 5'd0, 32'h0);
    send_beat(OP_DELETE, 5'd31, 32'h0);
    send_beat(OP_DELETE, 5'd2, 32'h0);
    send_beat(OP_DELETE, 5'd3, 32'h0);
    // Fill to capacity, alternating front and back.
    while (fill_level < CAPACITY)
      send_beat(OP_INSERT, (fill_level % 2) ? 5'd1 : POS_W'(fill_level + 1), $urandom);
    send_beat(OP_INSERT, 5'd17, 32'h5555_aaaa);  // valid position, list full
    send_beat(OP_INSERT, 5'd31, 32'haaaa_5555);  // range test wins over full test
    send_beat(OP_DELETE, 5'd16, 32'h0);          // last entry of a full list
    send_beat(OP_DELETE, 5'd1, 32'h0);

    // Random: mostly positions inside the list, with some noise across the
    // whole field; trends push the list between empty and full.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 32 == 0) begin
        tx_busy = pick_busy();
        trend   = trend_t'($urandom_range(0, 2));
      end
      gap = idle_len(tx_busy);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      if ($urandom_range(0, 99) < 12) begin
        op  = 1'($urandom_range(0, 1));
        pos = POS_W'($urandom_range(0, 31));
      end else begin
        case (trend)
          TREND_GROW:   op = ($urandom_range(0, 99) < 80) ? OP_INSERT : OP_DELETE;
          TREND_SHRINK: op = ($urandom_range(0, 99) < 20) ? OP_INSERT : OP_DELETE;
          default:      op = 1'($urandom_range(0, 1));
        endcase
        if (op == OP_DELETE && fill_level == 0) op = OP_INSERT;
        top_pos = (op == OP_INSERT) ? fill_level + 1 : fill_level;
        case ($urandom_range(0, 3))
          0:       pos = 5'd1;
          1:       pos = POS_W'(top_pos);
          default: pos = POS_W'($urandom_range(1, top_pos));
        endcase
      end
      send_beat(op, pos, pick_value());
    end
    in_valid = 1'b0;

    // Drain: wait for every outstanding result, then let the bench settle before the verdict.
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("** ordered_list_insert_delete_top: PASSED **");
    end else begin
      $display("** ordered_list_insert_delete_top: FAILED **");
    end
    $finish;
  end

endmodule
